>>> sv/secc_pkg.sv
// Package for the sensor EMA comfort classifier.
// Holds shared widths, filter constants, register indexes, class codes and structs.
// No dependencies.
package secc_pkg;

	localparam int SMOOTH_SHIFT = 4;
	localparam int FRAC_BITS    = 8;

	localparam int LIGHT_W = 16;
	localparam int SOUND_W = 16;
	localparam int TEMP_W  = 8;
	localparam int AVG_W   = 16;
	// Temperature arithmetic width: two guard bits above the average.
	localparam int TACC_W  = AVG_W + 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LOUD_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DARK_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOT_LIMIT      = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_COLD_LIMIT     = 2'd3;

	localparam logic [15:0] LOUD_RESET = 16'd3000;
	localparam logic [15:0] DARK_RESET = 16'd3000;
	localparam logic signed [7:0] HOT_RESET  = 8'sd30;
	localparam logic signed [7:0] COLD_RESET = 8'sd18;

	localparam int SCORE_W = 3;
	localparam logic [SCORE_W-1:0] WEIGHT_LOUD = 3'd3;
	localparam logic [SCORE_W-1:0] WEIGHT_DARK = 3'd2;
	localparam logic [SCORE_W-1:0] WEIGHT_TEMP = 3'd1;

	typedef enum logic [1:0] {
		CLASS_GOOD     = 2'd0,
		CLASS_MODERATE = 2'd1,
		CLASS_POOR     = 2'd2
	} comfort_class_t;

	localparam logic [6:0] BLEND_NONE = 7'd0;
	localparam logic [6:0] BLEND_LOW  = 7'd40;
	localparam logic [6:0] BLEND_HIGH = 7'd70;
	localparam logic [6:0] BLEND_FULL = 7'd100;

	typedef struct packed {
		logic [SOUND_W-1:0]       loud_threshold;
		logic [LIGHT_W-1:0]       dark_threshold;
		logic signed [TEMP_W-1:0] hot_limit;
		logic signed [TEMP_W-1:0] cold_limit;
	} cfg_t;

	typedef struct packed {
		logic [LIGHT_W-1:0]      light;
		logic [SOUND_W-1:0]      sound;
		logic signed [AVG_W-1:0] temp;
	} avg_t;

endpackage

>>> sv/secc_if.sv
// Valid/ready channel interfaces for the sensor EMA comfort classifier.
// Depends on secc_pkg for field widths.
interface secc_sample_if;
	import secc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [LIGHT_W-1:0]       light_sample;
	logic [SOUND_W-1:0]       sound_sample;
	logic signed [TEMP_W-1:0] temp_sample;

	modport source (output valid, light_sample, sound_sample, temp_sample, input ready);
	modport sink (input valid, light_sample, sound_sample, temp_sample, output ready);
endinterface

interface secc_result_if;
	import secc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [LIGHT_W-1:0]       light_average;
	logic [SOUND_W-1:0]       sound_average;
	logic signed [TEMP_W-1:0] temp_whole;
	logic [7:0]               temp_fraction;
	logic [1:0]               comfort_class;
	logic [6:0]               blend_level;

	modport source (output valid, light_average, sound_average, temp_whole, temp_fraction,
		comfort_class, blend_level, input ready);
	modport sink (input valid, light_average, sound_average, temp_whole, temp_fraction,
		comfort_class, blend_level, output ready);
endinterface

>>> sv/secc_filter.sv
// Moving average state and update logic for light, sound and temperature.
// Depends on secc_pkg.
module secc_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             update,
	input  logic [secc_pkg::LIGHT_W-1:0]     light_sample,
	input  logic [secc_pkg::SOUND_W-1:0]     sound_sample,
	input  logic signed [secc_pkg::TEMP_W-1:0] temp_sample,
	output secc_pkg::avg_t                   avg_next
);
	import secc_pkg::*;

	logic [LIGHT_W-1:0]       light_avg_q;
	logic [SOUND_W-1:0]       sound_avg_q;
	logic signed [AVG_W-1:0]  temp_avg_q;
	logic                     temp_seeded_q;

	logic signed [AVG_W-1:0]  temp_scaled;
	logic signed [TACC_W-1:0] temp_base;
	logic signed [TACC_W-1:0] temp_sum;
	logic signed [AVG_W-1:0]  temp_sat;

	always_comb begin
		avg_next.light = light_avg_q - (light_avg_q >> SMOOTH_SHIFT) + (light_sample >> SMOOTH_SHIFT);
		avg_next.sound = sound_avg_q - (sound_avg_q >> SMOOTH_SHIFT) + (sound_sample >> SMOOTH_SHIFT);

		temp_scaled = AVG_W'(temp_sample) <<< FRAC_BITS;
		// Before the first sample the average takes the scaled sample itself.
		temp_base = temp_seeded_q ? TACC_W'(temp_avg_q) : TACC_W'(temp_scaled);
		temp_sum  = temp_base - (temp_base >>> SMOOTH_SHIFT) + (TACC_W'(temp_scaled) >>> SMOOTH_SHIFT);

		if (temp_sum > TACC_W'(signed'({1'b0, {(AVG_W-1){1'b1}}}))) begin
			temp_sat = {1'b0, {(AVG_W-1){1'b1}}};
		end else if (temp_sum < TACC_W'(signed'({1'b1, {(AVG_W-1){1'b0}}}))) begin
			temp_sat = {1'b1, {(AVG_W-1){1'b0}}};
		end else begin
			temp_sat = temp_sum[AVG_W-1:0];
		end
		avg_next.temp = temp_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_avg_q   <= '0;
			sound_avg_q   <= '0;
			temp_avg_q    <= '0;
			temp_seeded_q <= 1'b0;
		end else if (update) begin
			light_avg_q   <= avg_next.light;
			sound_avg_q   <= avg_next.sound;
			temp_avg_q    <= avg_next.temp;
			temp_seeded_q <= 1'b1;
		end
	end

endmodule

>>> sv/secc_score.sv
// Threshold checks, weighted comfort score, and class and blend mapping.
// Depends on secc_pkg.
module secc_score (
	input  secc_pkg::cfg_t                   cfg,
	input  logic [secc_pkg::LIGHT_W-1:0]     light_sample,
	input  logic [secc_pkg::SOUND_W-1:0]     sound_sample,
	input  logic signed [secc_pkg::TEMP_W-1:0] temp_sample,
	output logic [1:0]                       comfort_class,
	output logic [6:0]                       blend_level
);
	import secc_pkg::*;

	logic [SCORE_W-1:0] score;

	always_comb begin
		score = '0;
		if (sound_sample > cfg.loud_threshold) score = score + WEIGHT_LOUD;
		if (light_sample > cfg.dark_threshold) score = score + WEIGHT_DARK;
		if (temp_sample > cfg.hot_limit) score = score + WEIGHT_TEMP;
		if (temp_sample < cfg.cold_limit) score = score + WEIGHT_TEMP;

		case (score) inside
			3'd0: begin
				comfort_class = CLASS_GOOD;
				blend_level   = BLEND_NONE;
			end
			3'd1, 3'd2: begin
				comfort_class = CLASS_MODERATE;
				blend_level   = BLEND_LOW;
			end
			3'd3: begin
				comfort_class = CLASS_POOR;
				blend_level   = BLEND_HIGH;
			end
			default: begin
				comfort_class = CLASS_POOR;
				blend_level   = BLEND_FULL;
			end
		endcase
	end

endmodule

>>> sv/sensor_ema_comfort_classifier_top.sv
// Top level of the sensor EMA comfort classifier: configuration registers,
// input and result registers. Depends on secc_pkg, secc_if, secc_filter, secc_score.
//
// Each sample item (light, sound, temperature) yields exactly one result item.
// The block is a two-register pipeline: an accepted item is held in an input
// register, where the moving-average update (a 1/16 shift-and-add on each
// channel, with temperature kept as a signed value scaled by 256) and the
// threshold score are computed, and is then loaded into the result register
// once that register is free, and the result is offered from there. A new
// item can be accepted every cycle while results are taken; the result
// register and the input register together hold two items, so the input side
// can accept one more item while one finished result waits to be taken. The
// averages advance only when an item moves from the input register into the
// result register, so every result reflects all earlier items in order. The
// very first temperature sample after reset seeds its average before the
// update. Light and sound averages are unsigned; temperature is reported as
// whole degrees (floor) and a fraction in 1/256 degree.
// The score adds 3 for sound above loud_threshold, 2 for light above
// dark_threshold and 1 each for temperature above hot_limit or below cold_limit;
// score 0 is class 0 (blend 0), 1 or 2 is class 1 (blend 40), 3 is class 2
// (blend 70) and anything higher is class 2 (blend 100). Configuration registers
// are written through cfg_wr_en, cfg_index and cfg_data and take effect at once;
// they should be written only while no item is in flight.
module sensor_ema_comfort_classifier_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [secc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [secc_pkg::CFG_DATA_W-1:0]  cfg_data,
	secc_sample_if.sink                      samples,
	secc_result_if.source                    results
);
	import secc_pkg::*;

	cfg_t cfg_q;

	logic                     valid_s1;
	logic [LIGHT_W-1:0]       light_s1;
	logic [SOUND_W-1:0]       sound_s1;
	logic signed [TEMP_W-1:0] temp_s1;

	logic                     valid_s2;
	logic [LIGHT_W-1:0]       light_avg_s2;
	logic [SOUND_W-1:0]       sound_avg_s2;
	logic signed [TEMP_W-1:0] temp_whole_s2;
	logic [7:0]               temp_fraction_s2;
	logic [1:0]               class_s2;
	logic [6:0]               blend_s2;

	logic                     s2_free;
	logic                     advance;
	avg_t                     avg_next;
	logic signed [AVG_W-1:0]  temp_whole_full;
	logic [1:0]               class_next;
	logic [6:0]               blend_next;

	// Configuration registers; an index with no register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loud_threshold <= LOUD_RESET;
			cfg_q.dark_threshold <= DARK_RESET;
			cfg_q.hot_limit      <= HOT_RESET;
			cfg_q.cold_limit     <= COLD_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOUD_THRESHOLD: cfg_q.loud_threshold <= cfg_data;
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data;
				REG_HOT_LIMIT:      cfg_q.hot_limit      <= cfg_data[TEMP_W-1:0];
				REG_COLD_LIMIT:     cfg_q.cold_limit     <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// The result register can load when it is empty or its item is being taken.
	assign s2_free       = !valid_s2 || results.ready;
	assign advance       = valid_s1 && s2_free;
	assign samples.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			light_s1 <= samples.light_sample;
			sound_s1 <= samples.sound_sample;
			temp_s1  <= samples.temp_sample;
		end
	end

	secc_filter u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (advance),
		.light_sample (light_s1),
		.sound_sample (sound_s1),
		.temp_sample  (temp_s1),
		.avg_next     (avg_next)
	);

	secc_score u_score (
		.cfg           (cfg_q),
		.light_sample  (light_s1),
		.sound_sample  (sound_s1),
		.temp_sample   (temp_s1),
		.comfort_class (class_next),
		.blend_level   (blend_next)
	);

	// Floor of the scaled average gives whole degrees; only the low byte is reported.
	assign temp_whole_full = avg_next.temp >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			light_avg_s2     <= avg_next.light;
			sound_avg_s2     <= avg_next.sound;
			temp_whole_s2    <= temp_whole_full[TEMP_W-1:0];
			temp_fraction_s2 <= avg_next.temp[7:0];
			class_s2         <= class_next;
			blend_s2         <= blend_next;
		end
	end

	assign results.valid         = valid_s2;
	assign results.light_average = light_avg_s2;
	assign results.sound_average = sound_avg_s2;
	assign results.temp_whole    = temp_whole_s2;
	assign results.temp_fraction = temp_fraction_s2;
	assign results.comfort_class = class_s2;
	assign results.blend_level   = blend_s2;

endmodule
